@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/slbw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbw_pkg
// Types, constants and readout mapping of the scanline line buffer writer.
// ----------------------------------------------------------------------------
package slbw_pkg;

  localparam int unsigned LINE_CELLS_DEF = 160;
  localparam int unsigned NUM_LANES      = 4;
  localparam int unsigned WIDE_LANES     = 2;
  localparam int unsigned BANK_SEL_W     = 2;
  localparam int unsigned ADDR_W         = 8;
  localparam int unsigned CELL_W         = 5;
  localparam int unsigned PIX_W          = 2;
  localparam int unsigned PAL_W          = 3;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned GADDR_W        = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KANGAROO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ADDR_W:0]   addr_ext_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_GFX    = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    RM_160   = 2'd0,
    RM_NONE  = 2'd1,
    RM_320BD = 2'd2,
    RM_320AC = 2'd3
  } rmode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_MAP  = 1'b1
  } state_e;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } lane_wr_t;

  typedef struct packed {
    cell_t left;
    cell_t right;
  } pix_pair_t;

  function automatic cell_t to_index(cell_t v);
    return (|v[PIX_W-1:0]) ? v : '0;
  endfunction

  function automatic pix_pair_t map_cell(rmode_e m, cell_t c);
    cell_t     l;
    cell_t     r;
    pix_pair_t p;
    unique case (m)
      RM_160: begin
        l = c;
        r = c;
      end
      RM_NONE: begin
        l = c;
        r = c;
      end
      RM_320BD: begin
        l = {c[4], 2'b00, c[1], c[3]};
        r = {c[4], 2'b00, c[0], c[2]};
      end
      RM_320AC: begin
        l = {c[4:1], 1'b0};
        r = {c[4:2], c[0], 1'b0};
      end
    endcase
    p.left  = to_index(l);
    p.right = to_index(r);
    return p;
  endfunction

endpackage

@@ rtl/core/slbw_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbw_lane
// One pixel lane: cell address, cell value and write enable for its pixel.
// ----------------------------------------------------------------------------
module slbw_lane #(
  parameter int unsigned LINE_CELLS = slbw_pkg::LINE_CELLS_DEF,
  parameter int unsigned LANE       = 0
) (
  input  slbw_pkg::addr_t              cursor_i,
  input  logic [slbw_pkg::PAL_W-1:0]   pal_i,
  input  logic                         wide_i,
  input  logic                         kangaroo_i,
  input  logic                         gfx_i,
  input  logic [slbw_pkg::BYTE_W-1:0]  byte_i,
  output slbw_pkg::lane_wr_t           wr_o
);
  import slbw_pkg::*;

  localparam int unsigned SH = PIX_W * (NUM_LANES - 1 - LANE);

  addr_t                   addr;
  logic [PIX_W-1:0]        npix;
  logic [2*PIX_W-1:0]      wpix;
  logic                    used;
  logic                    in_line;
  logic                    nz;
  cell_t                   val;

  always_comb begin
    addr = cursor_i + addr_t'(LANE);
    npix = byte_i[SH +: PIX_W];
    if (LANE == 0) begin
      wpix = {byte_i[3:2], byte_i[7:6]};
    end else begin
      wpix = {byte_i[1:0], byte_i[5:4]};
    end
    used    = !wide_i || (LANE < WIDE_LANES);
    in_line = addr_ext_t'(addr) < addr_ext_t'(LINE_CELLS);
    if (wide_i) begin
      nz  = |wpix;
      val = {pal_i[PAL_W-1], wpix};
    end else begin
      nz  = |npix;
      val = {pal_i, npix};
    end
    wr_o.en   = gfx_i && used && in_line && (nz || kangaroo_i);
    wr_o.addr = addr;
    wr_o.data = nz ? val : '0;
  end

endmodule

@@ rtl/core/slbw_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbw_bank
// One line buffer bank: one write and one registered read per cycle, with a
// valid bit per row so a clear takes effect at once.
// ----------------------------------------------------------------------------
module slbw_bank #(
  parameter int unsigned ROWS  = 40,
  parameter int unsigned ROW_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  wr_en_i,
  input  logic [ROW_W-1:0]      wr_row_i,
  input  slbw_pkg::cell_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ROW_W-1:0]      rd_row_i,
  output slbw_pkg::cell_t       rd_data_o,
  output logic                  rd_valid_o
);
  import slbw_pkg::*;

  cell_t             mem_q [ROWS];
  logic [ROWS-1:0]   valid_q;
  cell_t             rd_data_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_row_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ rtl/core/scanline_line_buffer_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_line_buffer_writer
// Line buffer of 5-bit cells filled from graphic bytes by four pixel lanes
// into four interleaved banks, read out one cell at a time as a pair of
// palette register offsets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  in       in         in_valid_i/in_stall_o    req_type_i .. cell_index_i
//  out      out        out_valid_o/out_stall_i  left/right_color_index_o
//
//  Clear, header and graphic words complete in the cycle they are accepted;
//  the four lanes write up to four cells in that cycle, one per bank.
//  A readout word passes through a registered bank read, then mapping into
//  the output register; it waits further while the output register stays full.
//  In read mode none a readout word completes in the cycle it is accepted and gives no output word.
//  Reset and clear drop the per-row valid bits, so every cell reads zero at
//  once with no sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scanline_line_buffer_writer #(
  parameter int unsigned LINE_CELLS = slbw_pkg::LINE_CELLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slbw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [slbw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     hpos_i,
  input  logic [2:0]                     palette_i,
  input  logic                           write_mode_i,
  input  logic [7:0]                     gfx_byte_i,
  input  logic [15:0]                    gfx_addr_i,
  input  logic                           holey_8_i,
  input  logic                           holey_16_i,
  input  logic [7:0]                     cell_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [4:0]                     left_color_index_o,
  output logic [4:0]                     right_color_index_o
);
  import slbw_pkg::*;

  localparam int unsigned BANK_ROWS = (LINE_CELLS + NUM_LANES - 1) / NUM_LANES;
  localparam int unsigned ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

  state_e                 state_q, state_d;
  logic                   kangaroo_q;
  rmode_e                 read_mode_q;
  addr_t                  cursor_q, cursor_d;
  logic [PAL_W-1:0]       pal_q;
  logic                   wide_q;
  logic                   out_valid_q;
  cell_t                  left_q, right_q;
  logic [BANK_SEL_W-1:0]  rd_bank_q;
  logic                   in_range_q;

  req_e                   req;
  logic                   in_acc;
  logic                   is_clr, is_hdr, is_gfx, is_rd;
  logic                   holey;
  logic [BYTE_W-1:0]      byte_eff;
  logic                   rd_in_range;
  logic                   rd_req;
  logic                   out_load;
  lane_wr_t               lane_wr [NUM_LANES];
  cell_t                  bank_data [NUM_LANES];
  logic [NUM_LANES-1:0]   bank_vld;
  logic [NUM_LANES-1:0]   bank_rd;
  cell_t                  rd_cell;
  pix_pair_t              pair;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign req         = req_e'(req_type_i);
  assign is_clr      = in_acc && (req == REQ_CLEAR);
  assign is_hdr      = in_acc && (req == REQ_HEADER);
  assign is_gfx      = in_acc && (req == REQ_GFX);
  assign is_rd       = in_acc && (req == REQ_READ);

  assign holey    = gfx_addr_i[15] &&
                    ((holey_16_i && gfx_addr_i[12]) || (holey_8_i && gfx_addr_i[11]));
  assign byte_eff = holey ? '0 : gfx_byte_i;

  assign rd_in_range = addr_ext_t'(cell_index_i) < addr_ext_t'(LINE_CELLS);
  assign rd_req      = is_rd && rd_in_range;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kangaroo_q  <= 1'b0;
      read_mode_q <= RM_160;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KANGAROO:  kangaroo_q  <= cfg_data_i[0];
        CFG_READ_MODE: read_mode_q <= rmode_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // object state
  always_comb begin
    cursor_d = cursor_q;
    if (is_hdr) begin
      cursor_d = hpos_i;
    end else if (is_gfx) begin
      cursor_d = cursor_q + (wide_q ? addr_t'(WIDE_LANES) : addr_t'(NUM_LANES));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      pal_q    <= '0;
      wide_q   <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      if (is_hdr) begin
        pal_q  <= palette_i;
        wide_q <= write_mode_i;
      end
    end
  end

  // pixel lanes
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    slbw_lane #(
      .LINE_CELLS (LINE_CELLS),
      .LANE       (k)
    ) u_lane (
      .cursor_i   (cursor_q),
      .pal_i      (pal_q),
      .wide_i     (wide_q),
      .kangaroo_i (kangaroo_q),
      .gfx_i      (is_gfx),
      .byte_i     (byte_eff),
      .wr_o       (lane_wr[k])
    );
  end

  // lane to bank routing and banks
  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    logic [BANK_SEL_W-1:0] sel;
    lane_wr_t              wr;

    assign sel        = BANK_SEL_W'(b) - cursor_q[BANK_SEL_W-1:0];
    assign wr         = lane_wr[sel];
    assign bank_rd[b] = rd_req && (cell_index_i[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

    slbw_bank #(
      .ROWS  (BANK_ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (is_clr),
      .wr_en_i    (wr.en),
      .wr_row_i   (wr.addr[BANK_SEL_W +: ROW_W]),
      .wr_data_i  (wr.data),
      .rd_en_i    (bank_rd[b]),
      .rd_row_i   (cell_index_i[BANK_SEL_W +: ROW_W]),
      .rd_data_o  (bank_data[b]),
      .rd_valid_o (bank_vld[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (is_rd) begin
      rd_bank_q  <= cell_index_i[BANK_SEL_W-1:0];
      in_range_q <= rd_in_range;
    end
  end

  assign rd_cell = (in_range_q && bank_vld[rd_bank_q]) ? bank_data[rd_bank_q] : '0;
  assign pair    = map_cell(read_mode_q, rd_cell);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (is_rd && (read_mode_q != RM_NONE)) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q  <= pair.left;
      right_q <= pair.right;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_color_index_o  = left_q;
  assign right_color_index_o = right_q;

  `ASSERT_NEXT(a_read_to_map, clk_i, rst_ni, is_rd && (read_mode_q != RM_NONE), state_q == ST_MAP)
  `ASSERT_NEXT(a_narrow_adv, clk_i, rst_ni, is_gfx && !wide_q, cursor_q == addr_t'($past(cursor_q) + addr_t'(NUM_LANES)))
  `ASSERT_NEXT(a_map_load, clk_i, rst_ni, out_load, out_valid_o && (state_q == ST_IDLE))
  `ASSERT_AT(a_one_bank_rd, clk_i, rst_ni, $onehot0(bank_rd))

endmodule
